[design/rcmr_pkg.sv]
// Shared constants and interface structs for the rod cutting revenue block.
`timescale 1ns / 1ps
`default_nettype none

package rcmr_pkg;

   // Fixed field widths of the transaction ports
   localparam int IDX_W = 7;
   localparam int VAL_W = 16;
   localparam int OUT_W = 22;

   // Command from the port side into the DP engine
   typedef struct packed {
      logic             load;
      logic             start;
      logic             ack;
      logic [IDX_W-1:0] index;
      logic [VAL_W-1:0] value;
      logic [IDX_W-1:0] length;
   } rcmr_cmd_type;

   // Status from the DP engine back to the port side
   typedef struct packed {
      logic             idle;
      logic             done;
      logic [OUT_W-1:0] result;
   } rcmr_stat_type;

endpackage

`default_nettype wire

[design/rcmr_engine.sv]
// DP engine: price and best-revenue memories with the bottom-up fill sequencer.
`timescale 1ns / 1ps
`default_nettype none

module rcmr_engine #(
   parameter int MAX_LEN    = 64,
   parameter int PRICE_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire rcmr_pkg::rcmr_cmd_type  cmd,
   output rcmr_pkg::rcmr_stat_type      stat
);
   import rcmr_pkg::*;

   // Lengths above the 7-bit index range can never be addressed
   localparam int IDX_MAX   = (1 << IDX_W) - 1;
   localparam int LEN_LIMIT = (MAX_LEN < IDX_MAX) ? MAX_LEN : IDX_MAX;
   localparam int AW        = (LEN_LIMIT > 1) ? $clog2(LEN_LIMIT) : 1;
   localparam int PW        = (PRICE_BITS < VAL_W) ? PRICE_BITS : VAL_W;
   localparam int REV_W     = PW + $clog2(LEN_LIMIT + 1);
   localparam logic [IDX_W-1:0] LEN_MAX_C = IDX_W'(LEN_LIMIT);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_WRITE = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  n_ff, n_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [REV_W-1:0]  top_ff, top_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              rd_last_ff, rd_last_in;
   logic [LEN_LIMIT-1:0] pvld_ff;
   logic              price_ok_ff;
   logic [PW-1:0]     price_rd_ff;
   logic [REV_W-1:0]  best_rd_ff;

   logic [PW-1:0]     price_mem_ff [LEN_LIMIT];
   logic [REV_W-1:0]  best_mem_ff  [LEN_LIMIT];

   logic              load_ok;
   logic [AW-1:0]     load_addr;
   logic [AW-1:0]     price_raddr;
   logic [AW-1:0]     best_raddr;
   logic [AW-1:0]     best_waddr;
   logic              best_we;
   logic [REV_W-1:0]  price_term;
   logic [REV_W-1:0]  best_term;
   logic [REV_W-1:0]  cand;
   logic [REV_W-1:0]  acc_top;
   logic [REV_W+OUT_W-1:0] res_wide;

   // Address decode
   assign load_ok     = cmd.load && (cmd.index != '0) && (cmd.index <= LEN_MAX_C);
   assign load_addr   = AW'(cmd.index - IDX_W'(1));
   assign price_raddr = AW'(j_ff - IDX_W'(1));
   assign best_raddr  = AW'(i_ff - j_ff - IDX_W'(1));
   assign best_waddr  = AW'(i_ff - IDX_W'(1));
   assign best_we     = (state_ff == ST_WRITE);

   // Candidate from last cycle's read; best of length zero is 0
   assign price_term = price_ok_ff ? REV_W'(price_rd_ff) : '0;
   assign best_term  = rd_last_ff ? '0 : best_rd_ff;
   assign cand       = price_term + best_term;
   assign acc_top    = (rd_vld_ff && (cand > top_ff)) ? cand : top_ff;

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      top_in     = acc_top;
      rd_vld_in  = 1'b0;
      rd_last_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               n_in   = (cmd.length > LEN_MAX_C) ? LEN_MAX_C : cmd.length;
               i_in   = IDX_W'(1);
               j_in   = IDX_W'(1);
               top_in = '0;
               state_in = (cmd.length == '0) ? ST_DONE : ST_READ;
            end
         end
         ST_READ: begin
            rd_vld_in  = 1'b1;
            rd_last_in = (j_ff == i_ff);
            if (j_ff == i_ff) begin
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            // top_ff goes to memory; keep it as the result on the last length
            if (i_ff == n_ff) begin
               top_in   = top_ff;
               state_in = ST_DONE;
            end else begin
               top_in   = '0;
               i_in     = i_ff + IDX_W'(1);
               j_in     = IDX_W'(1);
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (cmd.ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_vld_ff  <= 1'b0;
         rd_last_ff <= 1'b0;
         pvld_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         rd_last_ff <= rd_last_in;
         if ((state_ff == ST_IDLE) && load_ok) begin
            pvld_ff[load_addr] <= 1'b1;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      top_ff <= top_in;
   end

   // Price memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && load_ok) begin
         price_mem_ff[load_addr] <= cmd.value[PW-1:0];
      end
      price_rd_ff <= price_mem_ff[price_raddr];
      price_ok_ff <= pvld_ff[price_raddr];
   end

   // Best-revenue memory: written once per length, read during later lengths
   always_ff @(posedge clock) begin
      if (best_we) begin
         best_mem_ff[best_waddr] <= top_ff;
      end
      best_rd_ff <= best_mem_ff[best_raddr];
   end

   // Status out, result trimmed to the port width
   assign res_wide    = {{OUT_W{1'b0}}, top_ff};
   assign stat.idle   = (state_ff == ST_IDLE);
   assign stat.done   = (state_ff == ST_DONE);
   assign stat.result = res_wide[OUT_W-1:0];

   // Checks
   a_read_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> ((j_ff != '0) && (j_ff <= i_ff) && (i_ff <= n_ff)))
      else $error("inner index out of range");

   a_rd_source: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> ((state_ff == ST_READ) || (state_ff == ST_DRAIN)))
      else $error("read data pending outside the fill pass");

   a_last_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (rd_vld_ff && rd_last_ff))
      else $error("drain without the final candidate");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && $past(state_ff == ST_DONE)) |-> $stable(top_ff))
      else $error("result changed while waiting");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      best_we |=> (state_ff == ST_READ || state_ff == ST_DONE))
      else $error("unexpected state after best write");

endmodule

`default_nettype wire

[design/rod_cutting_max_revenue.sv]
// Top level: request/response handshake and result register around the DP engine.
// Sequence: a load writes one price entry; a solve of length n (capped at MAX_LEN) runs
//   READ, DRAIN and WRITE for each length 1..n, then loads the result register;
//   length zero skips the fill. Throughput: one transaction at a time; the inner
//   loop of the fill issues one price/best memory read pair per cycle.
// Reset: synchronous, active high; clears control state and the price valid bits,
//   so every price reads as zero until loaded. The best table is never cleared.
`timescale 1ns / 1ps
`default_nettype none

module rod_cutting_max_revenue #(
   parameter int MAX_LEN    = 64,
   parameter int PRICE_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire                          req_mode,
   input  wire  [rcmr_pkg::IDX_W-1:0]   req_price_index,
   input  wire  [rcmr_pkg::VAL_W-1:0]   req_price_value,
   input  wire  [rcmr_pkg::IDX_W-1:0]   req_rod_length,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [rcmr_pkg::OUT_W-1:0]   rsp_best_revenue
);
   import rcmr_pkg::*;

   rcmr_cmd_type     cmd;
   rcmr_stat_type    stat;
   logic             req_fire;
   logic             rsp_load;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] rsp_data_ff, rsp_data_in;

   // Request side: take a transaction whenever the engine is idle
   assign req_ready  = stat.idle;
   assign req_fire   = req_valid && req_ready;
   assign cmd.load   = req_fire && !req_mode;
   assign cmd.start  = req_fire && req_mode;
   assign cmd.index  = req_price_index;
   assign cmd.value  = req_price_value;
   assign cmd.length = req_rod_length;
   assign cmd.ack    = rsp_load;

   rcmr_engine #(
      .MAX_LEN    (MAX_LEN),
      .PRICE_BITS (PRICE_BITS)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   // Response register, refilled as soon as the previous result leaves
   assign rsp_load     = stat.done && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   assign rsp_data_in  = rsp_load ? stat.result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_best_revenue = rsp_data_ff;

endmodule

`default_nettype wire
